[rtl/sae_pkg.sv]
// Shared types, codes and constants for the sensor alarm escalation block.
// Used by the channel interfaces, the classifier and the top level; depends on nothing.
package sae_pkg;

  localparam int unsigned TIME_BITS_DEF = 32;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned CFG_DATA_W    = 16;
  localparam int unsigned NOW_W         = 32;
  localparam int unsigned FLAGS_W       = 9;

  localparam logic signed [15:0] GRADIENT_WATCH = 16'sd800;

  localparam int unsigned FLAG_LEVEL_OK   = 0;
  localparam int unsigned FLAG_IMU_OK     = 1;
  localparam int unsigned FLAG_AMBIENT_OK = 2;
  localparam int unsigned FLAG_PROBE      = 3;
  localparam int unsigned FLAG_LID_OPEN   = 4;
  localparam int unsigned FLAG_ENCLOSURE  = 5;
  localparam int unsigned FLAG_MAINS      = 6;
  localparam int unsigned FLAG_RTD_TOP    = 7;
  localparam int unsigned FLAG_RTD_BOTTOM = 8;

  typedef enum logic [0:0] {
    CMD_EVALUATE = 1'b0,
    CMD_ACK      = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    LVL_OK    = 2'd0,
    LVL_WATCH = 2'd1,
    LVL_WARN  = 2'd2,
    LVL_CRIT  = 2'd3
  } alarm_level_e;

  typedef enum logic [3:0] {
    RSN_NONE         = 4'd0,
    RSN_LEVEL_WARN   = 4'd1,
    RSN_LEVEL_CRIT   = 4'd2,
    RSN_DROP_RATE    = 4'd3,
    RSN_GRADIENT     = 4'd4,
    RSN_LID_OPEN     = 4'd5,
    RSN_TILT_WARN    = 4'd6,
    RSN_TILT_CRIT    = 4'd7,
    RSN_AMBIENT_HOT  = 4'd8,
    RSN_MAINS_LOST   = 4'd9,
    RSN_BATTERY_CRIT = 4'd10,
    RSN_ENCLOSURE    = 4'd11,
    RSN_PROBE_GONE   = 4'd12,
    RSN_SENSOR_FAULT = 4'd13
  } reason_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEVEL_CRIT   = 3'd0,
    CFG_LEVEL_WARN   = 3'd1,
    CFG_DROP_RATE    = 3'd2,
    CFG_TILT_CRIT    = 3'd3,
    CFG_TILT_WARN    = 3'd4,
    CFG_BATTERY_CRIT = 3'd5,
    CFG_LID_MINUTES  = 3'd6,
    CFG_AMBIENT_HOT  = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [9:0]         level_critical_limit;
    logic [9:0]         level_warning_limit;
    logic [13:0]        drop_rate_limit;
    logic [10:0]        tilt_critical_limit;
    logic [10:0]        tilt_warning_limit;
    logic [9:0]         battery_critical_limit;
    logic [15:0]        lid_open_minutes;
    logic signed [11:0] ambient_watch_limit;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    level_critical_limit:   10'd150,
    level_warning_limit:    10'd300,
    drop_rate_limit:        14'd50,
    tilt_critical_limit:    11'd300,
    tilt_warning_limit:     11'd150,
    battery_critical_limit: 10'd100,
    lid_open_minutes:       16'd5,
    ambient_watch_limit:    12'sd350
  };

  typedef struct packed {
    cmd_e               command;
    logic [NOW_W-1:0]   now_minutes;
    logic [FLAGS_W-1:0] status_flags;
    logic signed [10:0] level_percent;
    logic signed [14:0] level_fall_rate;
    logic [10:0]        tilt_angle;
    logic [9:0]         battery_percent;
    logic signed [11:0] ambient_temp;
    logic signed [15:0] temp_gradient;
  } in_item_t;

  typedef struct packed {
    alarm_level_e level;
    reason_e      reason;
  } verdict_t;

endpackage

[rtl/sae_in_if.sv]
// Input channel of the sensor alarm escalation block: valid, ready and one command item.
// Depends on sae_pkg for field widths.
interface sae_in_if;
  logic                       valid;
  logic                       ready;
  logic [0:0]                 command;
  logic [sae_pkg::NOW_W-1:0]  now_minutes;
  logic [sae_pkg::FLAGS_W-1:0] status_flags;
  logic signed [10:0]         level_percent;
  logic signed [14:0]         level_fall_rate;
  logic [10:0]                tilt_angle;
  logic [9:0]                 battery_percent;
  logic signed [11:0]         ambient_temp;
  logic signed [15:0]         temp_gradient;

  modport source (
    output valid, command, now_minutes, status_flags, level_percent, level_fall_rate,
           tilt_angle, battery_percent, ambient_temp, temp_gradient,
    input  ready
  );

  modport sink (
    input  valid, command, now_minutes, status_flags, level_percent, level_fall_rate,
           tilt_angle, battery_percent, ambient_temp, temp_gradient,
    output ready
  );
endinterface

[rtl/sae_out_if.sv]
// Result channel of the sensor alarm escalation block: valid, ready and one result item.
// Depends on sae_pkg for field widths.
interface sae_out_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                alarm_level;
  logic [3:0]                event_reason;
  logic [3:0]                held_reason;
  logic                      is_acked;
  logic [sae_pkg::NOW_W-1:0] level_entered_at;

  modport source (
    output valid, alarm_level, event_reason, held_reason, is_acked, level_entered_at,
    input  ready
  );

  modport sink (
    input  valid, alarm_level, event_reason, held_reason, is_acked, level_entered_at,
    output ready
  );
endinterface

[rtl/sae_classify.sv]
// First-match priority classifier of one evaluate item, with the next state of the lid timer.
// Purely combinational; depends on sae_pkg.
module sae_classify #(
  parameter int unsigned TIME_BITS = sae_pkg::TIME_BITS_DEF
) (
  input  sae_pkg::cfg_t         cfg_i,
  input  sae_pkg::in_item_t     item_i,
  input  logic [TIME_BITS-1:0]  now_i,
  input  sae_pkg::alarm_level_e level_i,
  input  logic                  lid_timing_i,
  input  logic [TIME_BITS-1:0]  lid_start_i,
  output logic                  lid_timing_o,
  output logic [TIME_BITS-1:0]  lid_start_o,
  output sae_pkg::verdict_t     verdict_o
);

  logic                 lvl_ok, imu_ok, amb_ok, probe, lid, enc, mains, rtd_top, rtd_bot;
  logic                 level_known, rate_pos;
  logic [TIME_BITS-1:0] start_eff;
  logic [TIME_BITS-1:0] elapsed;
  logic                 lid_late;

  assign lvl_ok  = item_i.status_flags[sae_pkg::FLAG_LEVEL_OK];
  assign imu_ok  = item_i.status_flags[sae_pkg::FLAG_IMU_OK];
  assign amb_ok  = item_i.status_flags[sae_pkg::FLAG_AMBIENT_OK];
  assign probe   = item_i.status_flags[sae_pkg::FLAG_PROBE];
  assign lid     = item_i.status_flags[sae_pkg::FLAG_LID_OPEN];
  assign enc     = item_i.status_flags[sae_pkg::FLAG_ENCLOSURE];
  assign mains   = item_i.status_flags[sae_pkg::FLAG_MAINS];
  assign rtd_top = item_i.status_flags[sae_pkg::FLAG_RTD_TOP];
  assign rtd_bot = item_i.status_flags[sae_pkg::FLAG_RTD_BOTTOM];

  assign level_known = ~item_i.level_percent[10];
  assign rate_pos    = ~item_i.level_fall_rate[14];

  assign start_eff = lid_timing_i ? lid_start_i : now_i;
  assign elapsed   = now_i - start_eff;
  assign lid_late  = elapsed >= TIME_BITS'(cfg_i.lid_open_minutes);

  always_comb begin
    lid_timing_o = lid_timing_i;
    lid_start_o  = lid_start_i;
    verdict_o    = '{level: sae_pkg::LVL_OK, reason: sae_pkg::RSN_NONE};
    if (lvl_ok && level_known &&
        (item_i.level_percent[9:0] < cfg_i.level_critical_limit)) begin
      verdict_o = '{level: sae_pkg::LVL_CRIT, reason: sae_pkg::RSN_LEVEL_CRIT};
    end else if (lvl_ok && rate_pos &&
                 (item_i.level_fall_rate[13:0] > cfg_i.drop_rate_limit)) begin
      verdict_o = '{level: sae_pkg::LVL_CRIT, reason: sae_pkg::RSN_DROP_RATE};
    end else if (imu_ok && (item_i.tilt_angle > cfg_i.tilt_critical_limit)) begin
      verdict_o = '{level: sae_pkg::LVL_CRIT, reason: sae_pkg::RSN_TILT_CRIT};
    end else if (item_i.battery_percent < cfg_i.battery_critical_limit) begin
      verdict_o = '{level: sae_pkg::LVL_CRIT, reason: sae_pkg::RSN_BATTERY_CRIT};
    end else if (!probe) begin
      verdict_o = '{level: sae_pkg::LVL_CRIT, reason: sae_pkg::RSN_PROBE_GONE};
    end else if (lvl_ok && level_known &&
                 (item_i.level_percent[9:0] < cfg_i.level_warning_limit)) begin
      verdict_o = '{level: sae_pkg::LVL_WARN, reason: sae_pkg::RSN_LEVEL_WARN};
    end else if (imu_ok && (item_i.tilt_angle > cfg_i.tilt_warning_limit)) begin
      verdict_o = '{level: sae_pkg::LVL_WARN, reason: sae_pkg::RSN_TILT_WARN};
    end else begin
      // The lid timer only moves once every higher-priority check has passed.
      if (lid) begin
        lid_timing_o = 1'b1;
        lid_start_o  = start_eff;
      end else begin
        lid_timing_o = 1'b0;
        lid_start_o  = '0;
      end
      if (lid && lid_late) begin
        verdict_o = '{level: sae_pkg::LVL_WARN, reason: sae_pkg::RSN_LID_OPEN};
      end else if (enc && (level_i >= sae_pkg::LVL_WARN)) begin
        verdict_o = '{level: sae_pkg::LVL_WARN, reason: sae_pkg::RSN_ENCLOSURE};
      end else if (amb_ok && (item_i.ambient_temp > cfg_i.ambient_watch_limit)) begin
        verdict_o = '{level: sae_pkg::LVL_WATCH, reason: sae_pkg::RSN_AMBIENT_HOT};
      end else if (!mains) begin
        verdict_o = '{level: sae_pkg::LVL_WATCH, reason: sae_pkg::RSN_MAINS_LOST};
      end else if (lvl_ok && rtd_top && rtd_bot &&
                   (item_i.temp_gradient < sae_pkg::GRADIENT_WATCH)) begin
        verdict_o = '{level: sae_pkg::LVL_WATCH, reason: sae_pkg::RSN_GRADIENT};
      end else if (!lvl_ok || !imu_ok || !amb_ok) begin
        verdict_o = '{level: sae_pkg::LVL_WATCH, reason: sae_pkg::RSN_SENSOR_FAULT};
      end
    end
  end

endmodule

[rtl/sensor_alarm_escalation.sv]
// Sensor alarm escalation: classifies readings and holds an acknowledged alarm level.
// Throughput is one item per cycle while the result register is not stalled by out ready.
// The held state is updated as an item leaves the input register for the result register.
// Reset clears the held level, reason, acknowledge, lid timer and entry time, and reloads
// the configuration registers with their default limits. Depends on sae_pkg, sae_in_if,
// sae_out_if and sae_classify.
module sensor_alarm_escalation #(
  parameter int unsigned TIME_BITS = sae_pkg::TIME_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [sae_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sae_pkg::CFG_DATA_W-1:0] cfg_data_i,
  sae_in_if.sink                         in_i,
  sae_out_if.source                      out_o
);

  sae_pkg::cfg_t         cfg_q;
  sae_pkg::in_item_t     in_q;
  logic                  in_valid_q;
  logic                  out_valid_q;
  logic                  out_free;
  logic                  advance;

  sae_pkg::alarm_level_e level_q, level_d;
  sae_pkg::reason_e      reason_q, reason_d;
  logic                  ack_q, ack_d;
  logic                  lid_timing_q, lid_timing_d;
  logic [TIME_BITS-1:0]  lid_start_q, lid_start_d;
  logic [sae_pkg::NOW_W-1:0] entered_q, entered_d;
  sae_pkg::reason_e      event_d;

  logic                  cls_timing;
  logic [TIME_BITS-1:0]  cls_start;
  sae_pkg::verdict_t     verdict;

  logic [63:0]           now_wide;
  logic [TIME_BITS-1:0]  now_t;
  logic [63:0]           now_t_wide;

  logic [1:0]            res_level_q;
  logic [3:0]            res_event_q;
  logic [3:0]            res_reason_q;
  logic                  res_ack_q;
  logic [sae_pkg::NOW_W-1:0] res_entered_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= sae_pkg::CFG_RESET;
    end else if (cfg_we_i) begin
      case (sae_pkg::cfg_idx_e'(cfg_idx_i))
        sae_pkg::CFG_LEVEL_CRIT:   cfg_q.level_critical_limit   <= cfg_data_i[9:0];
        sae_pkg::CFG_LEVEL_WARN:   cfg_q.level_warning_limit    <= cfg_data_i[9:0];
        sae_pkg::CFG_DROP_RATE:    cfg_q.drop_rate_limit        <= cfg_data_i[13:0];
        sae_pkg::CFG_TILT_CRIT:    cfg_q.tilt_critical_limit    <= cfg_data_i[10:0];
        sae_pkg::CFG_TILT_WARN:    cfg_q.tilt_warning_limit     <= cfg_data_i[10:0];
        sae_pkg::CFG_BATTERY_CRIT: cfg_q.battery_critical_limit <= cfg_data_i[9:0];
        sae_pkg::CFG_LID_MINUTES:  cfg_q.lid_open_minutes       <= cfg_data_i[15:0];
        sae_pkg::CFG_AMBIENT_HOT:  cfg_q.ambient_watch_limit    <= $signed(cfg_data_i[11:0]);
        default: begin
        end
      endcase
    end
  end

  // Handshake: the input register moves on whenever the result register is free.
  assign out_free   = !out_valid_q || out_o.ready;
  assign advance    = in_valid_q && out_free;
  assign in_i.ready = !in_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_q.command         <= sae_pkg::cmd_e'(in_i.command);
      in_q.now_minutes     <= in_i.now_minutes;
      in_q.status_flags    <= in_i.status_flags;
      in_q.level_percent   <= in_i.level_percent;
      in_q.level_fall_rate <= in_i.level_fall_rate;
      in_q.tilt_angle      <= in_i.tilt_angle;
      in_q.battery_percent <= in_i.battery_percent;
      in_q.ambient_temp    <= in_i.ambient_temp;
      in_q.temp_gradient   <= in_i.temp_gradient;
    end
  end

  assign now_wide   = 64'(in_q.now_minutes);
  assign now_t      = now_wide[TIME_BITS-1:0];
  assign now_t_wide = 64'(now_t);

  sae_classify #(
    .TIME_BITS (TIME_BITS)
  ) u_classify (
    .cfg_i        (cfg_q),
    .item_i       (in_q),
    .now_i        (now_t),
    .level_i      (level_q),
    .lid_timing_i (lid_timing_q),
    .lid_start_i  (lid_start_q),
    .lid_timing_o (cls_timing),
    .lid_start_o  (cls_start),
    .verdict_o    (verdict)
  );

  always_comb begin
    level_d      = level_q;
    reason_d     = reason_q;
    ack_d        = ack_q;
    lid_timing_d = lid_timing_q;
    lid_start_d  = lid_start_q;
    entered_d    = entered_q;
    event_d      = sae_pkg::RSN_NONE;
    if (in_q.command == sae_pkg::CMD_ACK) begin
      ack_d = 1'b1;
    end else begin
      lid_timing_d = cls_timing;
      lid_start_d  = cls_start;
      if (verdict.level > level_q) begin
        level_d   = verdict.level;
        reason_d  = verdict.reason;
        entered_d = now_t_wide[sae_pkg::NOW_W-1:0];
        ack_d     = 1'b0;
        event_d   = verdict.reason;
      end else if ((verdict.level < level_q) && ack_q) begin
        level_d   = verdict.level;
        reason_d  = verdict.reason;
        entered_d = now_t_wide[sae_pkg::NOW_W-1:0];
        ack_d     = 1'b0;
      end else if ((verdict.level == level_q) && (verdict.reason != sae_pkg::RSN_NONE)) begin
        reason_d = verdict.reason;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q      <= sae_pkg::LVL_OK;
      reason_q     <= sae_pkg::RSN_NONE;
      ack_q        <= 1'b0;
      lid_timing_q <= 1'b0;
      lid_start_q  <= '0;
      entered_q    <= '0;
    end else if (advance) begin
      level_q      <= level_d;
      reason_q     <= reason_d;
      ack_q        <= ack_d;
      lid_timing_q <= lid_timing_d;
      lid_start_q  <= lid_start_d;
      entered_q    <= entered_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_level_q   <= level_d;
      res_event_q   <= event_d;
      res_reason_q  <= reason_d;
      res_ack_q     <= ack_d;
      res_entered_q <= entered_d;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.alarm_level      = res_level_q;
  assign out_o.event_reason     = res_event_q;
  assign out_o.held_reason      = res_reason_q;
  assign out_o.is_acked         = res_ack_q;
  assign out_o.level_entered_at = res_entered_q;

`ifndef SYNTH
  // The held level is OK exactly when no reason is held.
  a_level_reason_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (level_q == sae_pkg::LVL_OK) == (reason_q == sae_pkg::RSN_NONE))
    else $error("held level and held reason disagree");

  // An escalation event always reports a raised, unacknowledged level.
  a_event_escalated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (res_event_q != sae_pkg::RSN_NONE)) |->
      ((res_level_q != sae_pkg::LVL_OK) && !res_ack_q))
    else $error("escalation event without a raised unacknowledged level");

  // An acknowledge transfer that leaves the input register sets the acknowledge.
  a_ack_sets_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && (in_q.command == sae_pkg::CMD_ACK)) |=> ack_q)
    else $error("acknowledge did not set the flag");

  // A rise of the held level always clears the acknowledge.
  a_rise_clears_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && (level_d > level_q)) |=> !ack_q)
    else $error("level rose but the acknowledge stayed set");
`endif

endmodule

[bench/tb_sensor_alarm_escalation.sv]
// Self-checking bench for sensor_alarm_escalation: directed and random readings, limit sweeps
// and long result back-pressure, every result checked against an in-bench alarm predictor.
// Depends on sae_pkg, sae_in_if, sae_out_if and the RTL of the block.
`timescale 1ns / 1ps

module tb_sensor_alarm_escalation;

  localparam logic [sae_pkg::FLAGS_W-1:0] HEALTHY_FLAGS = sae_pkg::FLAGS_W'(
      (1 << sae_pkg::FLAG_LEVEL_OK) | (1 << sae_pkg::FLAG_IMU_OK) |
      (1 << sae_pkg::FLAG_AMBIENT_OK) | (1 << sae_pkg::FLAG_PROBE) |
      (1 << sae_pkg::FLAG_MAINS) | (1 << sae_pkg::FLAG_RTD_TOP) |
      (1 << sae_pkg::FLAG_RTD_BOTTOM));

  typedef struct packed {
    sae_pkg::alarm_level_e     level;
    sae_pkg::reason_e          event_rsn;
    sae_pkg::reason_e          held_rsn;
    logic                      acked;
    logic [sae_pkg::NOW_W-1:0] since;
  } alarm_report_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni;
  logic                           cfg_we_i;
  logic [sae_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [sae_pkg::CFG_DATA_W-1:0] cfg_data_i;

  sae_in_if  in_ch ();
  sae_out_if out_ch ();

  sensor_alarm_escalation u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  always #2 clk_i = ~clk_i;

  sae_pkg::cfg_t             limits;
  sae_pkg::alarm_level_e     held_level;
  sae_pkg::reason_e          held_reason;
  logic                      held_acked;
  logic                      lid_running;
  logic [sae_pkg::NOW_W-1:0] lid_since;
  logic [sae_pkg::NOW_W-1:0] held_since;

  alarm_report_t             pending_reports[$];
  int unsigned               bad_reports = 0;
  int unsigned               burst_left = 0;
  bit                        gaps_enabled = 1'b1;
  int unsigned               hold_left = 0;
  logic [sae_pkg::NOW_W-1:0] minute_now = '0;
  bit                        lid_is_open = 1'b0;

  function automatic int rnd(int lo, int hi);
    return lo + int'($urandom_range(hi - lo, 0));
  endfunction

  function automatic alarm_report_t predict_report(sae_pkg::in_item_t it);
    sae_pkg::alarm_level_e cand;
    sae_pkg::reason_e      why;
    sae_pkg::reason_e      event_rsn;
    logic                  lvl_ok;
    logic                  imu_ok;
    logic                  amb_ok;
    int                    lvl;
    int                    rate;
    int                    tilt;
    int                    batt;
    int                    amb;
    cand = sae_pkg::LVL_OK;
    why = sae_pkg::RSN_NONE;
    event_rsn = sae_pkg::RSN_NONE;
    lvl_ok = it.status_flags[sae_pkg::FLAG_LEVEL_OK];
    imu_ok = it.status_flags[sae_pkg::FLAG_IMU_OK];
    amb_ok = it.status_flags[sae_pkg::FLAG_AMBIENT_OK];
    lvl = int'($signed(it.level_percent));
    rate = int'($signed(it.level_fall_rate));
    tilt = int'(it.tilt_angle);
    batt = int'(it.battery_percent);
    amb = int'($signed(it.ambient_temp));
    if (it.command == sae_pkg::CMD_ACK) begin
      held_acked = 1'b1;
    end else begin
      if (lvl_ok && lvl >= 0 && lvl < int'(limits.level_critical_limit)) begin
        cand = sae_pkg::LVL_CRIT; why = sae_pkg::RSN_LEVEL_CRIT;
      end else if (lvl_ok && rate > int'(limits.drop_rate_limit)) begin
        cand = sae_pkg::LVL_CRIT; why = sae_pkg::RSN_DROP_RATE;
      end else if (imu_ok && tilt > int'(limits.tilt_critical_limit)) begin
        cand = sae_pkg::LVL_CRIT; why = sae_pkg::RSN_TILT_CRIT;
      end else if (batt < int'(limits.battery_critical_limit)) begin
        cand = sae_pkg::LVL_CRIT; why = sae_pkg::RSN_BATTERY_CRIT;
      end else if (!it.status_flags[sae_pkg::FLAG_PROBE]) begin
        cand = sae_pkg::LVL_CRIT; why = sae_pkg::RSN_PROBE_GONE;
      end else if (lvl_ok && lvl >= 0 && lvl < int'(limits.level_warning_limit)) begin
        cand = sae_pkg::LVL_WARN; why = sae_pkg::RSN_LEVEL_WARN;
      end else if (imu_ok && tilt > int'(limits.tilt_warning_limit)) begin
        cand = sae_pkg::LVL_WARN; why = sae_pkg::RSN_TILT_WARN;
      end else begin
        // The lid timer only moves when none of the conditions above has fired.
        if (it.status_flags[sae_pkg::FLAG_LID_OPEN]) begin
          if (!lid_running) begin
            lid_running = 1'b1;
            lid_since = it.now_minutes;
          end
        end else begin
          lid_running = 1'b0;
          lid_since = '0;
        end
        if (it.status_flags[sae_pkg::FLAG_LID_OPEN] &&
            (it.now_minutes - lid_since) >= sae_pkg::NOW_W'(limits.lid_open_minutes)) begin
          cand = sae_pkg::LVL_WARN; why = sae_pkg::RSN_LID_OPEN;
        end else if (it.status_flags[sae_pkg::FLAG_ENCLOSURE] &&
                     held_level >= sae_pkg::LVL_WARN) begin
          cand = sae_pkg::LVL_WARN; why = sae_pkg::RSN_ENCLOSURE;
        end else if (amb_ok && amb > int'($signed(limits.ambient_watch_limit))) begin
          cand = sae_pkg::LVL_WATCH; why = sae_pkg::RSN_AMBIENT_HOT;
        end else if (!it.status_flags[sae_pkg::FLAG_MAINS]) begin
          cand = sae_pkg::LVL_WATCH; why = sae_pkg::RSN_MAINS_LOST;
        end else if (lvl_ok && it.status_flags[sae_pkg::FLAG_RTD_TOP] &&
                     it.status_flags[sae_pkg::FLAG_RTD_BOTTOM] &&
                     $signed(it.temp_gradient) < sae_pkg::GRADIENT_WATCH) begin
          cand = sae_pkg::LVL_WATCH; why = sae_pkg::RSN_GRADIENT;
        end else if (!lvl_ok || !imu_ok || !amb_ok) begin
          cand = sae_pkg::LVL_WATCH; why = sae_pkg::RSN_SENSOR_FAULT;
        end
      end
      if (cand > held_level) begin
        held_level = cand;
        held_reason = why;
        held_since = it.now_minutes;
        held_acked = 1'b0;
        event_rsn = why;
      end else if (cand < held_level && held_acked) begin
        held_level = cand;
        held_reason = why;
        held_since = it.now_minutes;
        held_acked = 1'b0;
      end else if (cand == held_level && why != sae_pkg::RSN_NONE) begin
        held_reason = why;
      end
    end
    return '{held_level, event_rsn, held_reason, held_acked, held_since};
  endfunction

  function automatic sae_pkg::in_item_t noise_item(sae_pkg::cmd_e cmd);
    sae_pkg::in_item_t it;
    it.command = cmd;
    it.now_minutes = $urandom();
    it.status_flags = sae_pkg::FLAGS_W'($urandom());
    it.level_percent = 11'(rnd(-1000, 1000));
    it.level_fall_rate = 15'(rnd(-10000, 10000));
    it.tilt_angle = 11'(rnd(0, 1800));
    it.battery_percent = 10'(rnd(0, 1000));
    it.ambient_temp = 12'(rnd(-400, 1250));
    it.temp_gradient = 16'($urandom());
    return it;
  endfunction

  function automatic sae_pkg::in_item_t healthy_item(logic [sae_pkg::NOW_W-1:0] stamp);
    sae_pkg::in_item_t it;
    int                lvl_floor;
    int                tilt_ceil;
    lvl_floor = (limits.level_critical_limit > limits.level_warning_limit) ?
                int'(limits.level_critical_limit) : int'(limits.level_warning_limit);
    tilt_ceil = (limits.tilt_critical_limit < limits.tilt_warning_limit) ?
                int'(limits.tilt_critical_limit) : int'(limits.tilt_warning_limit);
    it.command = sae_pkg::CMD_EVALUATE;
    it.now_minutes = stamp;
    it.status_flags = HEALTHY_FLAGS;
    it.level_percent = 11'(rnd(lvl_floor, 1000));
    it.level_fall_rate = 15'(rnd(-10000, int'(limits.drop_rate_limit)));
    it.tilt_angle = 11'(rnd(0, tilt_ceil));
    it.battery_percent = 10'(rnd(int'(limits.battery_critical_limit), 1000));
    it.ambient_temp = 12'(rnd(-400, int'($signed(limits.ambient_watch_limit))));
    it.temp_gradient = 16'(rnd(800, 32767));
    return it;
  endfunction

  function automatic sae_pkg::in_item_t disturb(sae_pkg::in_item_t it);
    sae_pkg::in_item_t noisy;
    noisy = noise_item(sae_pkg::CMD_EVALUATE);
    case ($urandom_range(11, 0))
      0: it.level_percent = noisy.level_percent;
      1: it.level_fall_rate = noisy.level_fall_rate;
      2: it.tilt_angle = noisy.tilt_angle;
      3: it.battery_percent = noisy.battery_percent;
      4: it.status_flags[sae_pkg::FLAG_PROBE] = 1'b0;
      5: it.status_flags[sae_pkg::FLAG_ENCLOSURE] = 1'b1;
      6: it.ambient_temp = noisy.ambient_temp;
      7: it.status_flags[sae_pkg::FLAG_MAINS] = 1'b0;
      8: it.temp_gradient = noisy.temp_gradient;
      9: it.status_flags[$urandom_range(sae_pkg::FLAG_AMBIENT_OK, sae_pkg::FLAG_LEVEL_OK)] = 1'b0;
      10: it.status_flags[sae_pkg::FLAG_RTD_TOP + $urandom_range(1, 0)] = 1'b0;
      default: begin
        noisy.now_minutes = it.now_minutes;
        it = noisy;
      end
    endcase
    return it;
  endfunction

  task automatic send_item(sae_pkg::in_item_t it);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(3, 0) == 0) ? 64 : $urandom_range(12, 1);
      if (gaps_enabled) begin
        repeat ($urandom_range(6, 1)) begin
          @(negedge clk_i);
          in_ch.valid <= 1'b0;
        end
      end
    end
    @(negedge clk_i);
    in_ch.valid <= 1'b1;
    in_ch.command <= it.command;
    in_ch.now_minutes <= it.now_minutes;
    in_ch.status_flags <= it.status_flags;
    in_ch.level_percent <= it.level_percent;
    in_ch.level_fall_rate <= it.level_fall_rate;
    in_ch.tilt_angle <= it.tilt_angle;
    in_ch.battery_percent <= it.battery_percent;
    in_ch.ambient_temp <= it.ambient_temp;
    in_ch.temp_gradient <= it.temp_gradient;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    pending_reports.push_back(predict_report(it));
    burst_left--;
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (pending_reports.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_limits(sae_pkg::cfg_t c);
    sae_pkg::cfg_idx_e              idx;
    logic [sae_pkg::CFG_DATA_W-1:0] d;
    wait_drained();
    idx = idx.first();
    do begin
      case (idx)
        sae_pkg::CFG_LEVEL_CRIT:   d = sae_pkg::CFG_DATA_W'(c.level_critical_limit);
        sae_pkg::CFG_LEVEL_WARN:   d = sae_pkg::CFG_DATA_W'(c.level_warning_limit);
        sae_pkg::CFG_DROP_RATE:    d = sae_pkg::CFG_DATA_W'(c.drop_rate_limit);
        sae_pkg::CFG_TILT_CRIT:    d = sae_pkg::CFG_DATA_W'(c.tilt_critical_limit);
        sae_pkg::CFG_TILT_WARN:    d = sae_pkg::CFG_DATA_W'(c.tilt_warning_limit);
        sae_pkg::CFG_BATTERY_CRIT: d = sae_pkg::CFG_DATA_W'(c.battery_critical_limit);
        sae_pkg::CFG_LID_MINUTES:  d = sae_pkg::CFG_DATA_W'(c.lid_open_minutes);
        default:                   d = sae_pkg::CFG_DATA_W'($signed(c.ambient_watch_limit));
      endcase
      @(negedge clk_i);
      cfg_we_i <= 1'b1;
      cfg_idx_i <= idx;
      cfg_data_i <= d;
      idx = idx.next();
    end while (idx != idx.first());
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    limits = c;
  endtask

  task automatic run_readings(int n);
    sae_pkg::in_item_t it;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(7, 0) == 0) begin
        it = noise_item(sae_pkg::CMD_ACK);
      end else begin
        if ($urandom_range(39, 0) == 0) minute_now = $urandom();
        else if ($urandom_range(9, 0) == 0) minute_now += $urandom_range(70000, 0);
        else minute_now += $urandom_range(3, 0);
        if ($urandom_range(11, 0) == 0) lid_is_open = !lid_is_open;
        it = healthy_item(minute_now);
        repeat ($urandom_range(2, 0)) it = disturb(it);
        it.status_flags[sae_pkg::FLAG_LID_OPEN] = lid_is_open;
      end
      send_item(it);
    end
  endtask

  task automatic test_directed_defaults();
    sae_pkg::in_item_t r;
    // A lid opened at minute zero is timed like any other.
    r = healthy_item(32'd0);
    r.status_flags[sae_pkg::FLAG_LID_OPEN] = 1'b1;
    r.level_percent = 11'sd1000;
    r.level_fall_rate = -15'sd10000;
    r.tilt_angle = '0;
    r.battery_percent = 10'd1000;
    r.ambient_temp = -12'sd400;
    r.temp_gradient = 16'sd32767;
    send_item(r);
    r = healthy_item(32'd3);
    r.status_flags[sae_pkg::FLAG_LID_OPEN] = 1'b1;
    send_item(r);
    r = healthy_item(32'd5);
    r.status_flags[sae_pkg::FLAG_LID_OPEN] = 1'b1;
    send_item(r);
    r = healthy_item(32'd6);
    r.status_flags[sae_pkg::FLAG_ENCLOSURE] = 1'b1;
    send_item(r);
    r = healthy_item(32'd7);
    r.tilt_angle = 11'd151;
    send_item(r);
    r = healthy_item(32'd8);
    r.level_percent = 11'sd299;
    send_item(r);
    send_item(noise_item(sae_pkg::CMD_ACK));
    r = healthy_item(32'd9);
    r.status_flags[sae_pkg::FLAG_MAINS] = 1'b0;
    send_item(r);
    r = healthy_item(32'd10);
    r.ambient_temp = 12'sd1250;
    send_item(r);
    r = healthy_item(32'd11);
    r.temp_gradient = 16'sh8000;
    send_item(r);
    r = healthy_item(32'd12);
    r.status_flags[sae_pkg::FLAG_LEVEL_OK] = 1'b0;
    r.level_percent = -11'sd1000;
    r.level_fall_rate = 15'sd10000;
    send_item(r);
    send_item(noise_item(sae_pkg::CMD_ACK));
    send_item(healthy_item(32'd13));
    r = healthy_item(32'd14);
    r.level_percent = '0;
    send_item(r);
    r = healthy_item(32'd15);
    r.level_fall_rate = 15'sd10000;
    send_item(r);
    r = healthy_item(32'd16);
    r.tilt_angle = 11'd1800;
    send_item(r);
    r = healthy_item(32'd17);
    r.battery_percent = '0;
    send_item(r);
    r = healthy_item(32'd18);
    r.status_flags[sae_pkg::FLAG_PROBE] = 1'b0;
    send_item(r);
    r = healthy_item(32'd19);
    r.level_percent = -11'sd1;
    send_item(r);
    send_item(noise_item(sae_pkg::CMD_ACK));
    send_item(noise_item(sae_pkg::CMD_ACK));
    // The elapsed lid time wraps across the top of the minute counter.
    r = healthy_item(32'hFFFF_FFFF);
    r.status_flags[sae_pkg::FLAG_LID_OPEN] = 1'b1;
    send_item(r);
    r = healthy_item(32'd4);
    r.status_flags[sae_pkg::FLAG_LID_OPEN] = 1'b1;
    send_item(r);
    r = noise_item(sae_pkg::CMD_EVALUATE);
    r.status_flags = '1;
    send_item(r);
  endtask

  task automatic test_limit_extremes();
    sae_pkg::cfg_t c;
    c = '0;
    c.ambient_watch_limit = -12'sd400;
    write_limits(c);
    run_readings(150);
    c = '{level_critical_limit: 10'd1000, level_warning_limit: 10'd1000,
          drop_rate_limit: 14'd10000, tilt_critical_limit: 11'd1800,
          tilt_warning_limit: 11'd1800, battery_critical_limit: 10'd1000,
          lid_open_minutes: 16'hFFFF, ambient_watch_limit: 12'sd1250};
    write_limits(c);
    run_readings(150);
  endtask

  task automatic test_random_limits();
    sae_pkg::cfg_t c;
    repeat (6) begin
      c.level_critical_limit = 10'(rnd(0, 1000));
      c.level_warning_limit = 10'(rnd(0, 1000));
      c.drop_rate_limit = 14'(rnd(0, 10000));
      c.tilt_critical_limit = 11'(rnd(0, 1800));
      c.tilt_warning_limit = 11'(rnd(0, 1800));
      c.battery_critical_limit = 10'(rnd(0, 1000));
      c.lid_open_minutes = ($urandom_range(1, 0) == 1) ? 16'(rnd(0, 20)) :
                           16'($urandom_range(65535, 0));
      c.ambient_watch_limit = 12'(rnd(-400, 1250));
      write_limits(c);
      run_readings(205);
    end
  endtask

  task automatic test_backpressure();
    hold_left = 300;
    gaps_enabled = 1'b0;
    run_readings(300);
    gaps_enabled = 1'b1;
  endtask

  initial begin : result_sink
    int unsigned cyc;
    cyc = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left != 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        case ((cyc / 97) % 4)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= 1'($urandom_range(1, 0));
          2: out_ch.ready <= (cyc % 3 != 0);
          default: out_ch.ready <= ($urandom_range(3, 0) == 0);
        endcase
      end
      cyc++;
    end
  end

  always @(posedge clk_i) begin : report_check
    alarm_report_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_reports.size() == 0) begin
        bad_reports++;
        if (bad_reports <= 10) $display("%0t: result transfer with nothing expected", $time);
      end else begin
        want = pending_reports.pop_front();
        if (out_ch.alarm_level !== want.level || out_ch.event_reason !== want.event_rsn ||
            out_ch.held_reason !== want.held_rsn || out_ch.is_acked !== want.acked ||
            out_ch.level_entered_at !== want.since) begin
          bad_reports++;
          if (bad_reports <= 10)
            $display("%0t: exp lvl %0d evt %0d held %0d ack %0d at %0h, got %0d %0d %0d %0d %0h",
                     $time, want.level, want.event_rsn, want.held_rsn, want.acked, want.since,
                     out_ch.alarm_level, out_ch.event_reason, out_ch.held_reason,
                     out_ch.is_acked, out_ch.level_entered_at);
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = sae_pkg::CFG_LEVEL_CRIT;
    cfg_data_i = '0;
    in_ch.valid = 1'b0;
    in_ch.command = sae_pkg::CMD_EVALUATE;
    in_ch.now_minutes = '0;
    in_ch.status_flags = '0;
    in_ch.level_percent = '0;
    in_ch.level_fall_rate = '0;
    in_ch.tilt_angle = '0;
    in_ch.battery_percent = '0;
    in_ch.ambient_temp = '0;
    in_ch.temp_gradient = '0;
    limits = sae_pkg::CFG_RESET;
    held_level = sae_pkg::LVL_OK;
    held_reason = sae_pkg::RSN_NONE;
    held_acked = 1'b0;
    lid_running = 1'b0;
    lid_since = '0;
    held_since = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed_defaults();
    test_limit_extremes();
    test_random_limits();
    test_backpressure();
    wait_drained();
    repeat (10) @(posedge clk_i);
    if (bad_reports == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
